### rtl/oskvt_pkg.sv
// ----------------------------------------------------------------------------
// oskvt_pkg
// Shared codes and types of the ordered small key/value table.
// ----------------------------------------------------------------------------
package oskvt_pkg;

   localparam logic [2:0] OP_LOOKUP       = 3'd0;
   localparam logic [2:0] OP_INSERT_FRONT = 3'd1;
   localparam logic [2:0] OP_INSERT_BACK  = 3'd2;
   localparam logic [2:0] OP_ERASE        = 3'd3;
   localparam logic [2:0] OP_OVERWRITE    = 3'd4;
   localparam logic [2:0] OP_RENAME       = 3'd5;
   localparam logic [2:0] OP_CLEAR        = 3'd6;
   localparam logic [2:0] OP_SET          = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MISSING   = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_CONFLICT  = 3'd4;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

### rtl/ordered_small_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_small_key_value_table
// Insertion-ordered key/value table with unique keys and status reporting.
// ----------------------------------------------------------------------------
// The keys of all entries are compared with the request in the cycle it is
// accepted, and the update and result are formed in the following execute
// cycle. busy is high during that execute cycle, and no new request is
// accepted while busy is high. The result word is shown on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, in the cycle after execute, and
// cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module ordered_small_key_value_table #(
   parameter int CAPACITY   = 8,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_operation,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [KEY_BITS-1:0]   req_new_key,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [2:0]            rsp_position,
   output logic [VALUE_BITS-1:0] rsp_found_value,
   output logic [3:0]            rsp_entry_count
);

   oskvt_pkg::cmd_type cmd;

   oskvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   oskvt_dp #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_new_key     (req_new_key),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted word produced no result");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without execute cycle");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != oskvt_pkg::ST_OK) |->
      (rsp_position == 3'd0 && rsp_found_value == '0))
      else $error("failed request returned nonzero position or value");
`endif

endmodule

### rtl/oskvt_ctrl.sv
// ----------------------------------------------------------------------------
// oskvt_ctrl
// Controller: accepts a request, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module oskvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output oskvt_pkg::cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic valid_ff;
   logic valid_in;

   always_comb begin
      state_in    = state_ff;
      valid_in    = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            valid_in    = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff == S_EXEC);
   assign rsp_valid = valid_ff;

endmodule

### rtl/oskvt_dp.sv
// ----------------------------------------------------------------------------
// oskvt_dp
// Datapath: entry registers, key compare, shift and update, result registers.
// ----------------------------------------------------------------------------
module oskvt_dp #(
   parameter int CAPACITY   = 8,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  oskvt_pkg::cmd_type    cmd,
   input  logic [2:0]            req_operation,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [KEY_BITS-1:0]   req_new_key,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic [2:0]            rsp_status,
   output logic [2:0]            rsp_position,
   output logic [VALUE_BITS-1:0] rsp_found_value,
   output logic [3:0]            rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [KEY_BITS-1:0]   key_ff [CAPACITY];
   logic [KEY_BITS-1:0]   key_in [CAPACITY];
   logic [VALUE_BITS-1:0] val_ff [CAPACITY];
   logic [VALUE_BITS-1:0] val_in [CAPACITY];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic [2:0]            op_ff;
   logic [KEY_BITS-1:0]   rkey_ff;
   logic [KEY_BITS-1:0]   rnew_key_ff;
   logic [VALUE_BITS-1:0] rvalue_ff;
   logic [CAPACITY-1:0]   hit_vec_ff;
   logic [CAPACITY-1:0]   hit_vec_in;
   logic                  nk_hit_ff;
   logic [CAPACITY-1:0]   nk_vec;

   logic [2:0]            status_ff;
   logic [2:0]            position_ff;
   logic [VALUE_BITS-1:0] found_ff;
   logic [3:0]            entry_count_ff;

   logic [CAPACITY-1:0]   at_or_after;
   logic [CAPACITY-1:0]   at_back;
   logic                  hit;
   logic                  full;
   logic [2:0]            hit_pos;
   logic [VALUE_BITS-1:0] hit_val;
   logic [2:0]            status;
   logic                  do_front;
   logic                  do_back;
   logic                  do_erase;
   logic                  do_overwrite;
   logic                  do_rename;
   logic                  do_clear;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_entry
         assign hit_vec_in[gi] = (key_ff[gi] == req_key) && (CNT_W'(gi) < count_ff);
         assign nk_vec[gi]     = (key_ff[gi] == req_new_key) && (CNT_W'(gi) < count_ff);
         assign at_back[gi]    = (count_ff == CNT_W'(gi));

         if (gi == 0) begin : g_first
            assign at_or_after[gi] = hit_vec_ff[gi];
         end else begin : g_rest
            assign at_or_after[gi] = at_or_after[gi-1] | hit_vec_ff[gi];
         end

         always_comb begin
            key_in[gi] = key_ff[gi];
            val_in[gi] = val_ff[gi];
            if (do_front) begin
               if (gi == 0) begin
                  key_in[gi] = rkey_ff;
                  val_in[gi] = rvalue_ff;
               end else begin
                  key_in[gi] = key_ff[(gi > 0) ? gi - 1 : 0];
                  val_in[gi] = val_ff[(gi > 0) ? gi - 1 : 0];
               end
            end else if (do_back && at_back[gi]) begin
               key_in[gi] = rkey_ff;
               val_in[gi] = rvalue_ff;
            end else if (do_erase && at_or_after[gi] && (gi + 1 < CAPACITY)) begin
               key_in[gi] = key_ff[(gi + 1 < CAPACITY) ? gi + 1 : gi];
               val_in[gi] = val_ff[(gi + 1 < CAPACITY) ? gi + 1 : gi];
            end else if (do_overwrite && hit_vec_ff[gi]) begin
               val_in[gi] = rvalue_ff;
            end else if (do_rename && hit_vec_ff[gi]) begin
               key_in[gi] = rnew_key_ff;
            end
         end
      end
   endgenerate

   always_comb begin
      hit_pos = 3'd0;
      hit_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_vec_ff[i]) begin
            hit_pos = hit_pos | 3'(i);
            hit_val = hit_val | val_ff[i];
         end
      end
   end

   assign hit  = |hit_vec_ff;
   assign full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      status       = oskvt_pkg::ST_OK;
      do_front     = 1'b0;
      do_back      = 1'b0;
      do_erase     = 1'b0;
      do_overwrite = 1'b0;
      do_rename    = 1'b0;
      do_clear     = 1'b0;
      case (op_ff)
         oskvt_pkg::OP_LOOKUP: begin
            if (!hit) status = oskvt_pkg::ST_MISSING;
         end
         oskvt_pkg::OP_INSERT_FRONT, oskvt_pkg::OP_INSERT_BACK: begin
            if (hit) begin
               status = oskvt_pkg::ST_DUPLICATE;
            end else if (full) begin
               status = oskvt_pkg::ST_FULL;
            end else if (op_ff == oskvt_pkg::OP_INSERT_FRONT) begin
               do_front = 1'b1;
            end else begin
               do_back = 1'b1;
            end
         end
         oskvt_pkg::OP_ERASE: begin
            if (!hit) status = oskvt_pkg::ST_MISSING;
            else do_erase = 1'b1;
         end
         oskvt_pkg::OP_OVERWRITE: begin
            if (!hit) status = oskvt_pkg::ST_MISSING;
            else do_overwrite = 1'b1;
         end
         oskvt_pkg::OP_RENAME: begin
            if ((rkey_ff != rnew_key_ff) && nk_hit_ff) status = oskvt_pkg::ST_DUPLICATE;
            else if (!hit) status = oskvt_pkg::ST_MISSING;
            else do_rename = 1'b1;
         end
         oskvt_pkg::OP_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            if (hit) begin
               if (hit_val != rvalue_ff) status = oskvt_pkg::ST_CONFLICT;
            end else if (full) begin
               status = oskvt_pkg::ST_FULL;
            end else begin
               do_back = 1'b1;
            end
         end
      endcase

      count_in = count_ff;
      if (do_clear) count_in = '0;
      else if (do_front || do_back) count_in = count_ff + CNT_W'(1);
      else if (do_erase) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         rkey_ff     <= req_key;
         rnew_key_ff <= req_new_key;
         rvalue_ff   <= req_value;
         hit_vec_ff  <= hit_vec_in;
         nk_hit_ff   <= |nk_vec;
      end
      if (cmd.execute) begin
         key_ff         <= key_in;
         val_ff         <= val_in;
         status_ff      <= status;
         entry_count_ff <= 4'(count_in);
         if (op_ff == oskvt_pkg::OP_LOOKUP && hit) begin
            position_ff <= hit_pos;
            found_ff    <= hit_val;
         end else begin
            position_ff <= 3'd0;
            found_ff    <= '0;
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_position    = position_ff;
   assign rsp_found_value = found_ff;
   assign rsp_entry_count = entry_count_ff;

endmodule
